// File: src/hpid_pkg.sv
// Shared types and constants for the heading PID controller with output clamp.
// Holds the transfer payload structs, register indexes and datapath widths.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hpid_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int TIME_DIVISOR = 1000;
   localparam int CMD_DIVISOR  = 10;

   localparam int DATA_W     = 32;
   localparam int INTEG_W    = 48;
   localparam int LIMIT_W    = 31;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int DIV_W  = 64;
   localparam int DEN_W  = 32;
   localparam int STEP_W = 7;

   localparam int MUL_M_W   = 48;
   localparam int MUL_B_W   = 32;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int PROD_W    = MUL_M_W + 1 + MUL_B_W;
   localparam int TERM_W    = 66;

   localparam logic [DATA_W-1:0]  GAIN_P_RESET = 32'd1638400;
   localparam logic [DATA_W-1:0]  GAIN_I_RESET = 32'd2621440;
   localparam logic [DATA_W-1:0]  GAIN_D_RESET = 32'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 31'd32768;

   typedef enum logic [1:0] {
      REG_GAIN_P       = 2'd0,
      REG_GAIN_I       = 2'd1,
      REG_GAIN_D       = 2'd2,
      REG_OUTPUT_LIMIT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] setpoint;
      logic [DATA_W-1:0]        stamp;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] command;
      logic                     held;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/hpid_div.sv
// Bit-serial restoring divider for the heading PID controller.
// Produces one quotient bit per cycle from a left-aligned unsigned dividend.
// Depends on hpid_pkg for its widths.
`default_nettype none

module hpid_div (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire [hpid_pkg::DIV_W-1:0]     num,
   input  wire [hpid_pkg::DEN_W-1:0]     den,
   input  wire [hpid_pkg::STEP_W-1:0]    steps,
   output logic                          busy,
   output logic [hpid_pkg::DIV_W-1:0]    quot
);
   import hpid_pkg::*;

   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_sub;
   logic              fits;

   always_comb begin
      trial     = {rem_ff, num_ff[DIV_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in  = {num_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - STEP_W'(1);
         busy_in = (cnt_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

// File: src/heading_pid_with_output_clamp.sv
// Top level of the heading PID controller with symmetric output clamp.
// Holds the APB register file, the sequencer and a bit-serial multiplier.
// Depends on hpid_pkg and hpid_div.
`default_nettype none

// Each request transfer carries a measured heading and a setpoint, both Q16.16, and a
// timestamp in source time units, and yields exactly one response transfer with the
// clamped rate command. A repeated timestamp returns the previous command with held
// set, passing from idle through S_PREP and S_OUT. A fresh sample runs through the
// serial units: the divider delivers one quotient bit per cycle (48 bits for dt, 49
// for the derivative, 63 for the final divide by ten) and the shift-add multiplier
// one multiplier bit per cycle (four products, two of them overlapped with
// divides). A new request is taken as soon as the sequencer is back in idle, even
// while the last response still waits for its transfer. Gains and the limit live at
// byte addresses 0, 4, 8 and 12 and should only be written while the block is idle.
module heading_pid_with_output_clamp (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire hpid_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output hpid_pkg::rsp_type                  rsp_payload,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [hpid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [hpid_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hpid_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import hpid_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_PREP = 8'b0000_0010,
      S_DT   = 8'b0000_0100,
      S_DD   = 8'b0000_1000,
      S_MI   = 8'b0001_0000,
      S_MD   = 8'b0010_0000,
      S_DC   = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_W-1:0]  gain_p_ff, gain_p_in;
   logic [DATA_W-1:0]  gain_i_ff, gain_i_in;
   logic [DATA_W-1:0]  gain_d_ff, gain_d_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic [DATA_W-1:0]  prev_stamp_ff, prev_stamp_in;
   logic [DATA_W-1:0]  prev_setpoint_ff, prev_setpoint_in;
   logic [DATA_W-1:0]  prev_error_ff, prev_error_in;
   logic [INTEG_W-1:0] integral_ff, integral_in;
   logic [DATA_W-1:0]  prev_command_ff, prev_command_in;

   req_type            in_ff, in_in;
   logic [DATA_W-1:0]  e_ff, e_in;
   logic [DATA_W-1:0]  d_ff, d_in;
   logic               d_neg_ff, d_neg_in;
   logic               s_neg_ff, s_neg_in;
   logic               held_ff, held_in;
   logic [TERM_W-1:0]  tp_ff, tp_in;
   logic [TERM_W-1:0]  ti_ff, ti_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [MUL_M_W-1:0]   mul_m_ff, mul_m_in;
   logic [MUL_B_W-1:0]   mul_b_ff, mul_b_in;
   logic [MUL_M_W:0]     acc_hi_ff, acc_hi_in;
   logic [MUL_CNT_W-1:0] mul_cnt_ff, mul_cnt_in;
   logic                 mul_busy_ff, mul_busy_in;
   logic                 mul_start;
   logic [MUL_M_W-1:0]   mul_m;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_M_W+1:0]   m_ext;
   logic [MUL_M_W+1:0]   addend;
   logic [MUL_M_W+1:0]   acc_sum;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_shift;

   logic               div_start;
   logic [DIV_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic [STEP_W-1:0]  div_steps;
   logic               div_busy;
   logic [DIV_W-1:0]   div_quot;

   logic               csr_write;
   reg_index_type      csr_index;

   logic [DATA_W:0]    e_wide;
   logic [DATA_W-1:0]  e_sat;
   logic [DATA_W-1:0]  stamp_diff;
   logic [DATA_W-1:0]  dt_fix;
   logic [DATA_W:0]    de;
   logic [DATA_W:0]    de_mag;
   logic [DATA_W-1:0]  d_sat;
   logic [INTEG_W:0]   inc;
   logic [INTEG_W+1:0] integ_sum;
   logic [INTEG_W-1:0] integ_sat;
   logic [TERM_W-1:0]  term_sum;
   logic [TERM_W-1:0]  s_mag;
   logic               over_limit;
   logic [DATA_W-1:0]  cmd_mag;
   logic [DATA_W-1:0]  cmd_clamped;

   hpid_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      limit_in  = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_P:       gain_p_in = csr_pwdata;
            REG_GAIN_I:       gain_i_in = csr_pwdata;
            REG_GAIN_D:       gain_d_in = csr_pwdata;
            REG_OUTPUT_LIMIT: limit_in  = csr_pwdata[LIMIT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GAIN_P:       csr_prdata = gain_p_ff;
         REG_GAIN_I:       csr_prdata = gain_i_ff;
         REG_GAIN_D:       csr_prdata = gain_d_ff;
         REG_OUTPUT_LIMIT: csr_prdata = {1'b0, limit_ff};
      endcase
   end

   // Shift-add multiplier: signed 48-bit multiplicand times signed 32-bit multiplier.
   // The product builds up in acc_hi_ff and the vacated low bits of mul_b_ff.
   always_comb begin
      m_ext       = {{2{mul_m_ff[MUL_M_W-1]}}, mul_m_ff};
      if (!mul_b_ff[0]) begin
         addend = '0;
      end else if (mul_cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
         addend = -m_ext;
      end else begin
         addend = m_ext;
      end
      acc_sum     = {acc_hi_ff[MUL_M_W], acc_hi_ff} + addend;
      mul_m_in    = mul_m_ff;
      mul_b_in    = mul_b_ff;
      acc_hi_in   = acc_hi_ff;
      mul_cnt_in  = mul_cnt_ff;
      mul_busy_in = mul_busy_ff;
      if (mul_start) begin
         mul_m_in    = mul_m;
         mul_b_in    = mul_b;
         acc_hi_in   = '0;
         mul_cnt_in  = '0;
         mul_busy_in = 1'b1;
      end else if (mul_busy_ff) begin
         acc_hi_in   = acc_sum[MUL_M_W+1:1];
         mul_b_in    = {acc_sum[0], mul_b_ff[MUL_B_W-1:1]};
         mul_cnt_in  = mul_cnt_ff + MUL_CNT_W'(1);
         mul_busy_in = (mul_cnt_ff != MUL_CNT_W'(MUL_B_W - 1));
      end
   end

   assign prod       = signed'({acc_hi_ff, mul_b_ff});
   assign prod_shift = prod >>> FRAC_BITS;

   // Datapath helpers with their saturation rules.
   always_comb begin
      e_wide = {in_ff.setpoint[DATA_W-1], in_ff.setpoint}
             - {in_ff.measured[DATA_W-1], in_ff.measured};
      if (e_wide[DATA_W] == e_wide[DATA_W-1]) begin
         e_sat = e_wide[DATA_W-1:0];
      end else begin
         e_sat = {e_wide[DATA_W], {(DATA_W-1){~e_wide[DATA_W]}}};
      end

      stamp_diff = in_ff.stamp - prev_stamp_ff;

      if (div_quot[DIV_W-1:DATA_W] != '0) begin
         dt_fix = '1;
      end else if (div_quot[DATA_W-1:0] == '0) begin
         dt_fix = DATA_W'(1);
      end else begin
         dt_fix = div_quot[DATA_W-1:0];
      end

      de     = {e_ff[DATA_W-1], e_ff} - {prev_error_ff[DATA_W-1], prev_error_ff};
      de_mag = de[DATA_W] ? -de : de;

      if (d_neg_ff) begin
         if ((div_quot[DIV_W-1:DATA_W] != '0)
             || (div_quot[DATA_W-1] && (div_quot[DATA_W-2:0] != '0))) begin
            d_sat = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            d_sat = -div_quot[DATA_W-1:0];
         end
      end else begin
         if (div_quot[DIV_W-1:DATA_W-1] != '0) begin
            d_sat = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            d_sat = div_quot[DATA_W-1:0];
         end
      end

      inc       = prod_shift[INTEG_W:0];
      integ_sum = {{2{integral_ff[INTEG_W-1]}}, integral_ff} + {inc[INTEG_W], inc};
      if ((integ_sum[INTEG_W+1:INTEG_W-1] == 3'b000)
          || (integ_sum[INTEG_W+1:INTEG_W-1] == 3'b111)) begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end else begin
         integ_sat = {integ_sum[INTEG_W+1], {(INTEG_W-1){~integ_sum[INTEG_W+1]}}};
      end

      term_sum = tp_ff + ti_ff + prod_shift[TERM_W-1:0];
      s_mag    = term_sum[TERM_W-1] ? -term_sum : term_sum;

      over_limit  = (div_quot > {{(DIV_W-LIMIT_W){1'b0}}, limit_ff});
      cmd_mag     = over_limit ? {1'b0, limit_ff} : div_quot[DATA_W-1:0];
      cmd_clamped = s_neg_ff ? -cmd_mag : cmd_mag;
   end

   // Sequencer.
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in         = state_ff;
      in_in            = in_ff;
      e_in             = e_ff;
      d_in             = d_ff;
      d_neg_in         = d_neg_ff;
      s_neg_in         = s_neg_ff;
      held_in          = held_ff;
      tp_in            = tp_ff;
      ti_in            = ti_ff;
      prev_stamp_in    = prev_stamp_ff;
      prev_setpoint_in = prev_setpoint_ff;
      prev_error_in    = prev_error_ff;
      integral_in      = integral_ff;
      prev_command_in  = prev_command_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      div_start        = 1'b0;
      div_num          = '0;
      div_den          = '0;
      div_steps        = '0;
      mul_start        = 1'b0;
      mul_m            = '0;
      mul_b            = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_in    = req_payload;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (in_ff.stamp == prev_stamp_ff) begin
               held_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               held_in          = 1'b0;
               e_in             = e_sat;
               prev_stamp_in    = in_ff.stamp;
               prev_setpoint_in = in_ff.setpoint;
               if (in_ff.setpoint != prev_setpoint_ff) begin
                  integral_in = '0;
               end
               div_start = 1'b1;
               div_num   = {stamp_diff, {(DIV_W-DATA_W){1'b0}}};
               div_den   = DEN_W'(TIME_DIVISOR);
               div_steps = STEP_W'(DATA_W + FRAC_BITS);
               mul_start = 1'b1;
               mul_m     = {{(MUL_M_W-DATA_W){e_sat[DATA_W-1]}}, e_sat};
               mul_b     = gain_p_ff;
               state_in  = S_DT;
            end
         end
         S_DT: begin
            if (!div_busy && !mul_busy_ff) begin
               tp_in         = prod_shift[TERM_W-1:0];
               d_neg_in      = de[DATA_W];
               prev_error_in = e_ff;
               div_start     = 1'b1;
               div_num       = {de_mag, {(DIV_W-DATA_W-1){1'b0}}};
               div_den       = dt_fix;
               div_steps     = STEP_W'(DATA_W + 1 + FRAC_BITS);
               mul_start     = 1'b1;
               mul_m         = {{(MUL_M_W-DATA_W){1'b0}}, dt_fix};
               mul_b         = e_ff;
               state_in      = S_DD;
            end
         end
         S_DD: begin
            if (!div_busy && !mul_busy_ff) begin
               integral_in = integ_sat;
               d_in        = d_sat;
               mul_start   = 1'b1;
               mul_m       = integ_sat;
               mul_b       = gain_i_ff;
               state_in    = S_MI;
            end
         end
         S_MI: begin
            if (!mul_busy_ff) begin
               ti_in     = prod_shift[TERM_W-1:0];
               mul_start = 1'b1;
               mul_m     = {{(MUL_M_W-DATA_W){d_ff[DATA_W-1]}}, d_ff};
               mul_b     = gain_d_ff;
               state_in  = S_MD;
            end
         end
         S_MD: begin
            if (!mul_busy_ff) begin
               s_neg_in  = term_sum[TERM_W-1];
               div_start = 1'b1;
               div_num   = {s_mag[DIV_W-2:0], 1'b0};
               div_den   = DEN_W'(CMD_DIVISOR);
               div_steps = STEP_W'(DIV_W - 1);
               state_in  = S_DC;
            end
         end
         S_DC: begin
            if (!div_busy) begin
               prev_command_in = cmd_clamped;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_in.command = prev_command_ff;
               rsp_in.held    = held_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         mul_busy_ff      <= 1'b0;
         mul_cnt_ff       <= '0;
         gain_p_ff        <= GAIN_P_RESET;
         gain_i_ff        <= GAIN_I_RESET;
         gain_d_ff        <= GAIN_D_RESET;
         limit_ff         <= LIMIT_RESET;
         prev_stamp_ff    <= '0;
         prev_setpoint_ff <= '0;
         prev_error_ff    <= '0;
         integral_ff      <= '0;
         prev_command_ff  <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         mul_busy_ff      <= mul_busy_in;
         mul_cnt_ff       <= mul_cnt_in;
         gain_p_ff        <= gain_p_in;
         gain_i_ff        <= gain_i_in;
         gain_d_ff        <= gain_d_in;
         limit_ff         <= limit_in;
         prev_stamp_ff    <= prev_stamp_in;
         prev_setpoint_ff <= prev_setpoint_in;
         prev_error_ff    <= prev_error_in;
         integral_ff      <= integral_in;
         prev_command_ff  <= prev_command_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      e_ff      <= e_in;
      d_ff      <= d_in;
      d_neg_ff  <= d_neg_in;
      s_neg_ff  <= s_neg_in;
      held_ff   <= held_in;
      tp_ff     <= tp_in;
      ti_ff     <= ti_in;
      rsp_ff    <= rsp_in;
      mul_m_ff  <= mul_m_in;
      mul_b_ff  <= mul_b_in;
      acc_hi_ff <= acc_hi_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_heading_pid_with_output_clamp.sv
// Self-checking testbench for heading_pid_with_output_clamp: directed samples, then
// random sample streams under several gain and clamp settings written over APB.
// Depends on hpid_pkg and the block's RTL; expected commands come from a local predictor.
module tb_heading_pid_with_output_clamp;
   import hpid_pkg::*;

   typedef logic signed [95:0] wide_type;

   localparam int          Q_SHIFT        = 16;
   localparam int          TICKS_PER_UNIT = 1000;
   localparam int          CMD_SCALE      = 10;
   localparam int          N_CASES        = 20;
   localparam int          N_PHASES       = 6;
   localparam int          PHASE_SAMPLES  = 140;
   localparam int          DRAIN_CYCLES   = 250;
   localparam int unsigned CYCLE_LIMIT    = 2000000;

   localparam wide_type TERM_LIM = wide_type'(1) <<< 60;
   localparam wide_type I48_MAX  = (wide_type'(1) <<< 47) - 1;
   localparam wide_type I48_MIN  = -(wide_type'(1) <<< 47);
   localparam wide_type I32_MAX  = (wide_type'(1) <<< 31) - 1;
   localparam wide_type I32_MIN  = -(wide_type'(1) <<< 31);

   typedef struct packed {
      logic [31:0] measured;
      logic [31:0] setpoint;
      logic [31:0] stamp;
      logic        known;
      logic [31:0] command;
      logic        held;
   } heading_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // Predictor state and configuration.
   logic signed [31:0] gain_p_cfg = 32'sd1638400;
   logic signed [31:0] gain_i_cfg = 32'sd2621440;
   logic signed [31:0] gain_d_cfg = 32'sd0;
   logic [30:0]        limit_cfg  = 31'd32768;
   logic [31:0]        last_stamp = '0;
   logic signed [31:0] last_setpoint = '0;
   logic signed [31:0] last_error = '0;
   wide_type           error_sum = '0;
   logic signed [31:0] last_command = '0;

   rsp_type     pending_commands[$];
   int          errors = 0;
   int unsigned cycle_count = 0;
   int          burst_left = 0;
   logic [31:0] walk_stamp = '0;
   logic signed [31:0] walk_setpoint = '0;
   logic [15:0] drain_mask = 16'hFFFF;
   logic [3:0]  mask_pos = '0;

   logic [31:0] corner_values [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};

   heading_case_type heading_cases [N_CASES] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_03E8, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h1234_5678, 32'h0000_0000, 32'h0000_03E8, 1'b1, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_07D0, 1'b1, 32'h0000_8000, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0BB8, 1'b1, 32'hFFFF_8000, 1'b0},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0BB8, 1'b1, 32'hFFFF_8000, 1'b1},
      '{32'h0001_0000, 32'h0001_8000, 32'h0000_0005, 1'b0, 32'h0, 1'b0},
      '{32'h0001_0000, 32'h0001_8000, 32'hF000_0005, 1'b0, 32'h0, 1'b0},
      '{32'h0001_0000, 32'h0001_8000, 32'hF000_0006, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hF000_0007, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hF000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_1388, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_2710, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_3A98, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 32'h0000_4E20, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_0000, 32'h0001_0000, 32'h0000_61A8, 1'b0, 32'h0, 1'b0}
   };

   heading_pid_with_output_clamp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic wide_type clip(input wide_type v, input wide_type lo,
                                     input wide_type hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_type heading_command(input req_type r);
      rsp_type     res;
      logic [31:0] span;
      logic [63:0] step_raw;
      wide_type    step_q16, err, rate, inc, tp, ti, td, cmd, lim;
      if (r.stamp == last_stamp) begin
         res.command = last_command;
         res.held    = 1'b1;
         return res;
      end
      span     = r.stamp - last_stamp;
      step_raw = {16'd0, span, 16'd0} / 64'(TICKS_PER_UNIT);
      if (step_raw > 64'hFFFF_FFFF) step_raw = 64'hFFFF_FFFF;
      if (step_raw == 64'd0) step_raw = 64'd1;
      step_q16 = wide_type'(step_raw);
      if ($signed(r.setpoint) != last_setpoint) error_sum = '0;
      last_setpoint = r.setpoint;
      last_stamp    = r.stamp;
      err  = clip(wide_type'($signed(r.setpoint)) - wide_type'($signed(r.measured)),
                  I32_MIN, I32_MAX);
      rate = clip(((err - wide_type'(last_error)) <<< Q_SHIFT) / step_q16, I32_MIN, I32_MAX);
      last_error = err[31:0];
      inc       = clip((err * step_q16) >>> Q_SHIFT, I48_MIN, I48_MAX);
      error_sum = clip(error_sum + inc, I48_MIN, I48_MAX);
      tp  = clip((wide_type'(gain_p_cfg) * err) >>> Q_SHIFT, -TERM_LIM, TERM_LIM);
      ti  = clip((wide_type'(gain_i_cfg) * error_sum) >>> Q_SHIFT, -TERM_LIM, TERM_LIM);
      td  = clip((wide_type'(gain_d_cfg) * rate) >>> Q_SHIFT, -TERM_LIM, TERM_LIM);
      cmd = (tp + ti + td) / wide_type'(CMD_SCALE);
      lim = wide_type'({1'b0, limit_cfg});
      if (cmd > lim) cmd = lim;
      else if (cmd < -lim) cmd = -lim;
      last_command = cmd[31:0];
      res.command  = cmd[31:0];
      res.held     = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 100) begin
         $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      end
      errors++;
   endtask

   // Each register write is followed by a read of the same register.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] seen;
      logic [31:0] held_value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_GAIN_P: begin
            gain_p_cfg = value;
            held_value = value;
         end
         REG_GAIN_I: begin
            gain_i_cfg = value;
            held_value = value;
         end
         REG_GAIN_D: begin
            gain_d_cfg = value;
            held_value = value;
         end
         default: begin
            limit_cfg  = value[30:0];
            held_value = {1'b0, value[30:0]};
         end
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== held_value) report_mismatch(idx.name(), seen, held_value);
   endtask

   task automatic send_sample(input req_type r, input rsp_type want);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 7))
            0, 1: gap = 0;
            2: gap = $urandom_range(200, 280);
            default: gap = $urandom_range(1, 20);
         endcase
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      pending_commands.push_back(want);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   // Mostly plausible sample streams, with repeats, jumps and raw noise mixed in.
   task automatic next_sample(output req_type r);
      int pick;
      pick = $urandom_range(0, 99);
      r.measured = walk_setpoint + int'($urandom_range(0, 2097152)) - 1048576;
      if (pick < 70) begin
         walk_stamp += $urandom_range(1, 20000);
         if ($urandom_range(0, 9) == 0) begin
            walk_setpoint = int'($urandom_range(0, 23592960)) - 11796480;
            r.measured = walk_setpoint + int'($urandom_range(0, 2097152)) - 1048576;
         end
      end else if (pick < 78) begin
         r.measured = $urandom();
      end else if (pick < 84) begin
         walk_stamp -= $urandom_range(1, 100000);
      end else if (pick < 90) begin
         walk_stamp    = $urandom();
         walk_setpoint = $urandom();
         r.measured    = $urandom();
      end else if (pick < 95) begin
         walk_stamp += $urandom_range(70000000, 32'h8000_0000);
      end else begin
         walk_stamp   += $urandom_range(1, 20000);
         walk_setpoint = corner_values[$urandom_range(0, 4)];
         r.measured    = corner_values[$urandom_range(0, 4)];
      end
      r.setpoint = walk_setpoint;
      r.stamp    = walk_stamp;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (pending_commands.size() == 0) begin
               report_mismatch("unexpected response command", got.command, 32'h0);
            end else begin
               want = pending_commands.pop_front();
               if (got.command !== want.command) begin
                  report_mismatch("command", got.command, want.command);
               end
               if (got.held !== want.held) begin
                  report_mismatch("held", {31'd0, got.held}, {31'd0, want.held});
               end
            end
         end
         mask_pos <= mask_pos + 4'd1;
         if (mask_pos == 4'hF && $urandom_range(0, 7) == 0) begin
            drain_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
         end
         rsp_ready <= drain_mask[mask_pos];
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int          k;
      int          ph;
      req_type     sample;
      rsp_type     want;
      logic [31:0] gp, gi, gd, lim;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (k = 0; k < N_CASES; k++) begin
         sample.measured = heading_cases[k].measured;
         sample.setpoint = heading_cases[k].setpoint;
         sample.stamp    = heading_cases[k].stamp;
         want = heading_command(sample);
         if (heading_cases[k].known) begin
            want.command = heading_cases[k].command;
            want.held    = heading_cases[k].held;
         end
         send_sample(sample, want);
      end
      walk_stamp    = last_stamp;
      walk_setpoint = last_setpoint;
      for (ph = 0; ph < N_PHASES; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin
               gp = 32'h0001_8000; gi = 32'h0000_4000; gd = 32'h0000_1999; lim = 32'h7FFF_FFFF;
            end
            1: begin
               gp = 32'h7FFF_FFFF; gi = 32'h8000_0000; gd = 32'h7FFF_FFFF; lim = 32'hFFFF_FFFF;
            end
            2: begin
               gp = 32'h8000_0000; gi = 32'h7FFF_FFFF; gd = 32'h8000_0000; lim = 32'h0;
            end
            4: begin
               gp = 32'hFFFE_8000; gi = 32'hFFFF_0000; gd = 32'h0002_0000; lim = 32'h00A0_0000;
            end
            default: begin
               gp = $urandom(); gi = $urandom(); gd = $urandom(); lim = $urandom();
            end
         endcase
         csr_write(REG_GAIN_P, gp);
         csr_write(REG_GAIN_I, gi);
         csr_write(REG_GAIN_D, gd);
         csr_write(REG_OUTPUT_LIMIT, lim);
         for (k = 0; k < PHASE_SAMPLES; k++) begin
            next_sample(sample);
            send_sample(sample, heading_command(sample));
         end
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
src/hpid_pkg.sv
src/hpid_div.sv
src/heading_pid_with_output_clamp.sv
tb/sv/tb_heading_pid_with_output_clamp.sv
